/* hw/rtl/dense_graph_min_spanning_tree_top_assert.svh */
// Assertion macros for the spanning tree block.
// Used by dense_graph_min_spanning_tree_top; needs clk and arst_n in scope.
`ifndef DENSE_GRAPH_MIN_SPANNING_TREE_TOP_ASSERT_SVH
`define DENSE_GRAPH_MIN_SPANNING_TREE_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define DGM_ASSERT_IMPL(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);
// Next-cycle implication checked on every rising clock edge outside reset.
`define DGM_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);
`endif

/* hw/rtl/dgmst_pkg.sv */
// Shared types and constants for the spanning tree block.
// No dependencies.
package dgmst_pkg;
	localparam int unsigned NoEdgeWeight = 9999;
	localparam int unsigned CostBits = 18;
	localparam int unsigned VtxBits = 4;

	typedef struct packed {
		logic load;       // write the input entry into the store
		logic run_init;   // reset sets and sums
		logic scan_start; // clear best and restart the scan position
		logic scan_step;  // evaluate one store entry
		logic commit;     // join sets, add cost, build result
		logic emit_disc;  // build disconnected result
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_done;  // last store entry evaluated
		logic found;      // a joining edge was found this scan
		logic tree_done;  // edge count reached n-1
		logic find_busy;  // commit root walk not yet done (high outside a finishing commit)
	} dp_status_t;
endpackage

/* hw/rtl/dgmst_datapath.sv */
// Datapath: weight store, parent links, scan position, best candidate, root walk.
// Depends on dgmst_pkg.
module dgmst_datapath #(
	parameter int unsigned MAX_VERTICES = 16,
	parameter int unsigned WEIGHT_BITS = 14,
	parameter int unsigned VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dgmst_pkg::ctl_cmd_t          cmd,
	output dgmst_pkg::dp_status_t        status,
	input  logic [3:0]                   in_row,
	input  logic [3:0]                   in_col,
	input  logic [13:0]                  in_weight,
	input  logic                         in_absent,
	input  logic [4:0]                   vertex_count,
	output logic [3:0]                   res_num,
	output logic [3:0]                   res_from,
	output logic [3:0]                   res_to,
	output logic [13:0]                  res_cost,
	output logic [17:0]                  res_total,
	output logic                         res_disc,
	output logic                         res_last
);
	localparam int unsigned Depth = MAX_VERTICES * MAX_VERTICES;
	localparam int unsigned AB = 2 * VB;
	localparam int unsigned SB = $clog2(MAX_VERTICES + 1);

	logic [WEIGHT_BITS:0] mem_q [Depth];
	logic [WEIGHT_BITS:0] rd_q;
	logic [VB-1:0] parent_q [MAX_VERTICES];
	logic [VB-1:0] si_q, sj_q;       // address being read
	logic [VB-1:0] ei_q, ej_q;       // entry whose data is in rd_q
	logic rd_vld_q, last_rd_q, issue_done_q;
	logic [VB-1:0] wi_q, wj_q;       // root walk pointers
	logic [SB-1:0] steps_q;
	logic [WEIGHT_BITS:0] best_q;
	logic [VB-1:0] ba_q, bb_q;
	logic found_q;
	logic [3:0] edges_q;
	logic [17:0] cost_q;
	logic [SB-1:0] n_c;
	logic walking_q, scan_done_q;

	always_comb begin
		if (vertex_count < 5'd2) n_c = SB'(2);
		else if (32'(vertex_count) > MAX_VERTICES) n_c = SB'(MAX_VERTICES);
		else n_c = SB'(vertex_count);
	end

	// store write / registered read
	always_ff @(posedge clk) begin
		if (cmd.load && 32'(in_row) < MAX_VERTICES && 32'(in_col) < MAX_VERTICES)
			mem_q[AB'(32'(in_row) * MAX_VERTICES + 32'(in_col))] <=
				{in_absent, in_absent ? WEIGHT_BITS'(0) : WEIGHT_BITS'(in_weight)};
		rd_q <= mem_q[AB'(32'(si_q) * MAX_VERTICES + 32'(sj_q))];
	end

	logic at_end_c;
	assign at_end_c = (SB'(si_q) == n_c - SB'(1)) && (SB'(sj_q) == n_c - SB'(1));
	logic wi_root, wj_root, steps_out;
	assign wi_root = parent_q[wi_q] == wi_q;
	assign wj_root = parent_q[wj_q] == wj_q;
	assign steps_out = steps_q >= SB'(MAX_VERTICES);
	logic walk_done;
	assign walk_done = (wi_root && wj_root) || steps_out;
	logic [WEIGHT_BITS:0] nolimit;
	assign nolimit = (WEIGHT_BITS+1)'(dgmst_pkg::NoEdgeWeight);

	// One read in flight; each entry: read, then walk roots of both ends if it improves on best.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < MAX_VERTICES; v++) parent_q[v] <= VB'(v);
			rd_vld_q <= 1'b0; walking_q <= 1'b0; scan_done_q <= 1'b0;
			found_q <= 1'b0; edges_q <= '0; cost_q <= '0;
			si_q <= '0; sj_q <= '0; issue_done_q <= 1'b0; last_rd_q <= 1'b0;
		end else begin
			if (cmd.run_init) begin
				for (int v = 0; v < MAX_VERTICES; v++) parent_q[v] <= VB'(v);
				edges_q <= '0; cost_q <= '0;
			end
			if (cmd.scan_start) begin
				si_q <= '0; sj_q <= '0; found_q <= 1'b0;
				best_q <= nolimit; rd_vld_q <= 1'b0; walking_q <= 1'b0;
				scan_done_q <= 1'b0; issue_done_q <= 1'b0;
			end else if (cmd.scan_step) begin
				if (!rd_vld_q && !walking_q && !issue_done_q) begin
					rd_vld_q <= 1'b1; ei_q <= si_q; ej_q <= sj_q;
					last_rd_q <= at_end_c;
				end else if (rd_vld_q) begin
					rd_vld_q <= 1'b0;
					if (!rd_q[WEIGHT_BITS] && rd_q[WEIGHT_BITS-1:0] < best_q) begin
						walking_q <= 1'b1; wi_q <= ei_q; wj_q <= ej_q;
						steps_q <= '0;
					end else begin
						if (last_rd_q) scan_done_q <= 1'b1;
						else if (SB'(sj_q) == n_c - SB'(1)) begin
							sj_q <= '0; si_q <= si_q + VB'(1);
						end else sj_q <= sj_q + VB'(1);
					end
				end else if (walking_q) begin
					if (walk_done) begin
						walking_q <= 1'b0;
						if (wi_q != wj_q) begin
							best_q <= {1'b0, rd_q[WEIGHT_BITS-1:0]};
							ba_q <= ei_q; bb_q <= ej_q; found_q <= 1'b1;
						end
						if (last_rd_q) scan_done_q <= 1'b1;
						else if (SB'(sj_q) == n_c - SB'(1)) begin
							sj_q <= '0; si_q <= si_q + VB'(1);
						end else sj_q <= sj_q + VB'(1);
					end else begin
						if (!wi_root) wi_q <= parent_q[wi_q];
						if (!wj_root) wj_q <= parent_q[wj_q];
						steps_q <= steps_q + SB'(1);
					end
				end
			end
			if (cmd.commit) begin
				// wi_q/wj_q no longer valid; walk again via walk registers
				if (!walking_q) begin
					walking_q <= 1'b1; wi_q <= ba_q; wj_q <= bb_q; steps_q <= '0;
				end else if (walk_done) begin
					walking_q <= 1'b0;
					parent_q[wj_q] <= wi_q;
					cost_q <= cost_q + 18'(best_q[WEIGHT_BITS-1:0]);
					edges_q <= edges_q + 4'd1;
				end else begin
					if (!wi_root) wi_q <= parent_q[wi_q];
					if (!wj_root) wj_q <= parent_q[wj_q];
					steps_q <= steps_q + SB'(1);
				end
			end
		end
	end

	logic commit_fire;
	assign commit_fire = cmd.commit && walking_q && walk_done;

	always_ff @(posedge clk) begin
		if (commit_fire) begin
			res_num <= edges_q; res_from <= 4'(ba_q); res_to <= 4'(bb_q);
			res_cost <= 14'(best_q[WEIGHT_BITS-1:0]);
			res_total <= cost_q + 18'(best_q[WEIGHT_BITS-1:0]);
			res_disc <= 1'b0;
			res_last <= (SB'(edges_q) + SB'(1)) == (n_c - SB'(1));
		end else if (cmd.emit_disc) begin
			res_num <= edges_q; res_from <= '0; res_to <= '0; res_cost <= '0;
			res_total <= cost_q; res_disc <= 1'b1; res_last <= 1'b1;
		end
	end

	assign status.scan_done = scan_done_q;
	assign status.found = found_q;
	assign status.tree_done = SB'(edges_q) >= n_c - SB'(1);
	assign status.find_busy = !commit_fire;
endmodule

/* hw/rtl/dgmst_ctrl.sv */
// Controller state machine for the spanning tree block.
// Depends on dgmst_pkg.
module dgmst_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_fire,
	input  logic                  s_last,
	output logic                  s_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output dgmst_pkg::ctl_cmd_t   cmd,
	input  dgmst_pkg::dp_status_t status
);
	typedef enum logic [5:0] {
		ST_LOAD   = 6'b000001,
		ST_START  = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_COMMIT = 6'b001000,
		ST_EMIT   = 6'b010000,
		ST_DISC   = 6'b100000
	} state_t;
	state_t st_q;
	logic disc_q;

	assign s_ready = (st_q == ST_LOAD);
	assign out_valid = (st_q == ST_EMIT);

	always_comb begin
		cmd = '0;
		cmd.load = s_fire;
		cmd.run_init = s_fire && s_last;
		case (st_q)
			ST_START:  cmd.scan_start = 1'b1;
			ST_SCAN:   cmd.scan_step = !status.scan_done;
			ST_COMMIT: cmd.commit = 1'b1;
			ST_DISC:   cmd.emit_disc = 1'b1;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD; disc_q <= 1'b0;
		end else begin
			case (st_q)
				ST_LOAD: if (s_fire && s_last) st_q <= ST_START;
				ST_START: st_q <= ST_SCAN;
				ST_SCAN: if (status.scan_done) begin
					st_q <= status.found ? ST_COMMIT : ST_DISC;
				end
				ST_COMMIT: if (!status.find_busy) st_q <= ST_EMIT;
				ST_DISC: begin
					disc_q <= 1'b1; st_q <= ST_EMIT;
				end
				ST_EMIT: if (out_ready) begin
					if (disc_q || status.tree_done) begin
						st_q <= ST_LOAD; disc_q <= 1'b0;
					end else st_q <= ST_START;
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end
endmodule

/* hw/rtl/dense_graph_min_spanning_tree_top.sv */
// Top level of the dense-graph minimum spanning tree block.
// Depends on dgmst_pkg, dgmst_ctrl, dgmst_datapath and the assertion header.
//
// Usage:
//  - s_axis carries matrix entries, one item per cycle while loading.
//    tdata = {pad, absent, weight[13:0], col[3:0], row[3:0]}; tlast = last_entry.
//  - The item with last_entry set starts a run: s_axis_tready drops until the
//    run has delivered all its results on m_axis.
//  - Each round scans the n x n store, reading and then evaluating one entry
//    at a time, plus a root walk for each improving candidate; one item per
//    tree edge, or one disconnected item ending the run.
//  - Run time is set by the single read port of the weight store and the
//    serial root walk.
//  - cfg_valid/cfg_ready write vertex_count; write only while idle.
//  - Reset puts vertex_count at 16 and parent links at identity; the weight
//    store is undefined until written.
//  - A stalled m_axis holds its item; the block waits in the emit state.
`include "dense_graph_min_spanning_tree_top_assert.svh"
module dense_graph_min_spanning_tree_top #(
	parameter int unsigned MAX_VERTICES = 16,
	parameter int unsigned WEIGHT_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // row[3:0], col[7:4], weight[21:8], absent[22], pad
	input  logic        s_axis_tlast,  // last_entry
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // edge_number, from, to, cost, total, pad
	output logic        m_axis_tuser,  // disconnected
	output logic        m_axis_tlast,  // last_edge
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data       // vertex_count
);
	dgmst_pkg::ctl_cmd_t cmd;
	dgmst_pkg::dp_status_t status;
	logic [4:0] vcount_q;
	logic s_fire;
	logic [3:0] r_num, r_from, r_to;
	logic [13:0] r_cost;
	logic [17:0] r_total;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vcount_q <= 5'd16;
		else if (cfg_valid) vcount_q <= cfg_data;
	end

	assign s_fire = s_axis_tvalid && s_axis_tready;

	dgmst_ctrl u_ctrl (
		.clk, .arst_n, .s_fire, .s_last(s_axis_tlast), .s_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .cmd, .status
	);

	dgmst_datapath #(.MAX_VERTICES(MAX_VERTICES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
		.clk, .arst_n, .cmd, .status,
		.in_row(s_axis_tdata[3:0]), .in_col(s_axis_tdata[7:4]),
		.in_weight(s_axis_tdata[21:8]), .in_absent(s_axis_tdata[22]),
		.vertex_count(vcount_q),
		.res_num(r_num), .res_from(r_from), .res_to(r_to), .res_cost(r_cost),
		.res_total(r_total), .res_disc(m_axis_tuser), .res_last(m_axis_tlast)
	);

	assign m_axis_tdata = {4'd0, r_total, r_cost, r_to, r_from, r_num};

	// no entry is taken while results are pending
	`DGM_ASSERT_IMPL(a_no_load_emit, m_axis_tvalid, !s_axis_tready, "load during emit")
	// a disconnected item always ends the run
	`DGM_ASSERT_IMPL(a_disc_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast,
		"disconnected item not last")
	// a stalled item holds
	`DGM_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")
endmodule
